// File: rtl/rdns_pkg.sv
// shared types and constants for the regulatory window nearest-site block
// no dependencies; imported by every module of the block
package rdns_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;

	// field widths
	localparam int CHROM_W    = 8;
	localparam int POS_W      = 31;
	localparam int REACH_W    = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(50000);
	localparam logic [POS_W-1:0]   POS_MAX     = {POS_W{1'b1}};

	// request types
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_CLEARED = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REACH_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [CHROM_W-1:0] chromosome_id;
		logic [POS_W-1:0]   site_position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [POS_W-1:0]   window_start;
		logic [POS_W-1:0]   window_stop;
		logic               upstream_found;
		logic               downstream_found;
		logic [REACH_W-1:0] upstream_distance;
		logic [REACH_W-1:0] downstream_distance;
	} rsp_t;

	// one table entry
	typedef struct packed {
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0]   pos;
	} site_t;

	// running outcome of a neighbour scan
	typedef struct packed {
		logic               up_found;
		logic               down_found;
		logic [REACH_W-1:0] up_dist;
		logic [REACH_W-1:0] down_dist;
	} scan_t;

endpackage

// File: rtl/rdns_site_mem.sv
// site table: single write port, single read port, registered read data
// depends on rdns_pkg for table depth and entry type
module rdns_site_mem
	import rdns_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  site_t             wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output site_t             rdata
);

	site_t mem [TABLE_DEPTH];
	site_t rdata_q;

	// write and read never share a cycle: loads commit outside the scan
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rdns_window.sv
// window edge arithmetic from the final scan outcome
// depends on rdns_pkg for widths and the scan_t type
module rdns_window
	import rdns_pkg::*;
(
	input  logic             mode,
	input  logic [POS_W-1:0] pos,
	input  scan_t            scan,
	output logic [POS_W-1:0] start,
	output logic [POS_W-1:0] stop
);

	logic [REACH_W:0]   up_round;
	logic [REACH_W-1:0] up_half;
	logic [REACH_W-1:0] down_half;
	logic [POS_W:0]     start_diff;
	logic [POS_W:0]     stop_sum;

	// halfway edges round the upstream side up and the downstream side down
	always_comb begin
		up_round  = {1'b0, scan.up_dist} + (REACH_W+1)'(1);
		up_half   = (mode && scan.up_found) ? up_round[REACH_W:1] : scan.up_dist;
		down_half = (mode && scan.down_found) ? (scan.down_dist >> 1) : scan.down_dist;
	end

	// start clamps at zero, stop saturates at the position maximum
	always_comb begin
		start_diff = {1'b0, pos} - (POS_W+1)'(up_half);
		stop_sum   = {1'b0, pos} + (POS_W+1)'(down_half);
		start      = start_diff[POS_W] ? '0 : start_diff[POS_W-1:0];
		stop       = stop_sum[POS_W] ? POS_MAX : stop_sum[POS_W-1:0];
	end

endmodule

// File: rtl/regulatory_domain_nearest_sites_core.sv
// regulatory window from nearest sites: top level with control and scan
// load, clear and unused requests skip the scan and go straight to the result state;
// a query scans the filled entries, one table read per cycle from the site memory
// throughput: one request at a time, the next transfer in the cycle after the result is stored
// reset: entry count zero, mode 0, reach 50000; table contents are kept, never cleared
module regulatory_domain_nearest_sites_core
	import rdns_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  req_t                  item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output rsp_t                  result
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_WIN  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic               window_mode_q;
	logic [REACH_W-1:0] reach_limit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               rd_valid_s1;
	req_t               req_q;
	scan_t              scan_q;
	logic [POS_W-1:0]   win_start_q;
	logic [POS_W-1:0]   win_stop_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic               accept;
	logic               commit;
	logic               table_full;
	logic               mem_we;
	logic               mem_re;
	site_t              mem_wdata;
	site_t              mem_rdata;
	logic [POS_W-1:0]   win_start;
	logic [POS_W-1:0]   win_stop;
	logic [POS_W:0]     down_diff;
	logic [POS_W:0]     up_diff;
	logic               down_hit;
	logic               up_hit;
	rsp_t               rsp;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign commit       = (state_q == S_DONE) && (!out_valid_q || result_ready);
	assign table_full   = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_mode_q <= 1'b0;
			reach_limit_q <= REACH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_MODE: window_mode_q <= cfg_data[0];
				REG_REACH_LIMIT: reach_limit_q <= cfg_data[REACH_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (item.req_type == REQ_QUERY) ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (rd_cnt_q == cnt_q) begin
					state_d = S_WIN;
				end
			end
			S_WIN:  state_d = S_DONE;
			S_DONE: begin
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= item;
		end
	end

	// table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (commit && req_q.req_type == REQ_CLEAR) begin
			cnt_q <= '0;
		end else if (mem_we) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// read issue over the filled part of the table
	assign mem_re = (state_q == S_SCAN) && (rd_cnt_q != cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (mem_re) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	assign mem_we          = commit && (req_q.req_type == REQ_LOAD) && !table_full;
	assign mem_wdata.chrom = req_q.chromosome_id;
	assign mem_wdata.pos   = req_q.site_position;

	rdns_site_mem u_site_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_cnt_q[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	// distance compare against the entry read last cycle
	always_comb begin
		down_diff = {1'b0, mem_rdata.pos} - {1'b0, req_q.site_position};
		up_diff   = {1'b0, req_q.site_position} - {1'b0, mem_rdata.pos};
		down_hit  = (mem_rdata.pos > req_q.site_position)
			&& (down_diff[POS_W-1:0] < POS_W'(scan_q.down_dist));
		up_hit    = (mem_rdata.pos < req_q.site_position)
			&& (up_diff[POS_W-1:0] < POS_W'(scan_q.up_dist));
	end

	// nearest neighbour accumulation
	always_ff @(posedge clk) begin
		if (accept) begin
			scan_q.up_found   <= 1'b0;
			scan_q.down_found <= 1'b0;
			scan_q.up_dist    <= reach_limit_q;
			scan_q.down_dist  <= reach_limit_q;
		end else if (rd_valid_s1 && mem_rdata.chrom == req_q.chromosome_id) begin
			if (down_hit) begin
				scan_q.down_found <= 1'b1;
				scan_q.down_dist  <= down_diff[REACH_W-1:0];
			end else if (up_hit) begin
				scan_q.up_found <= 1'b1;
				scan_q.up_dist  <= up_diff[REACH_W-1:0];
			end
		end
	end

	rdns_window u_window (
		.mode  (window_mode_q),
		.pos   (req_q.site_position),
		.scan  (scan_q),
		.start (win_start),
		.stop  (win_stop)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_WIN) begin
			win_start_q <= win_start;
			win_stop_q  <= win_stop;
		end
	end

	// result assembly by request type
	always_comb begin
		rsp = '0;
		unique case (req_q.req_type)
			REQ_LOAD:  rsp.status = table_full ? ST_FULL : ST_DONE;
			REQ_QUERY: begin
				rsp.status              = ST_DONE;
				rsp.window_start        = win_start_q;
				rsp.window_stop         = win_stop_q;
				rsp.upstream_found      = scan_q.up_found;
				rsp.downstream_found    = scan_q.down_found;
				rsp.upstream_distance   = scan_q.up_dist;
				rsp.downstream_distance = scan_q.down_dist;
			end
			REQ_CLEAR: rsp.status = ST_CLEARED;
			default:   rsp.status = ST_DONE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= rsp;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rd_valid_s1 && !mem_re)
		else $error("table write overlaps a scan read");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> rd_cnt_q < cnt_q)
		else $error("read beyond filled entries");

	a_dist_in_reach: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WIN) |-> scan_q.up_dist <= reach_limit_q
			&& scan_q.down_dist <= reach_limit_q)
		else $error("neighbour distance beyond reach");

	a_commit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_ready) |=> $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule
